/* design/aalr_pkg.sv */
// Shared types, constants and helpers of the anti-aliased line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package aalr_pkg;

    // Field widths of the external words
    localparam int CRD_W    = 16;
    localparam int OFFSET_W = 26;
    localparam int WEIGHT_W = 17;
    localparam int DIM_W    = 13;

    // Fixed-point and range constants
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_DIM    = 4096;

    // Internal widths
    localparam int MAJOR_W = CRD_W + 1;
    localparam int PIX_W   = CRD_W + 2;
    localparam int ROW_W   = 12;
    localparam int LIN_W   = ROW_W + DIM_W;
    localparam int REM_W   = CRD_W + 2;
    localparam int CNT_W   = 5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]    DIV_STEPS  = CNT_W'(FRAC_BITS);
    localparam logic [DIM_W-1:0]    DIM_LIMIT  = DIM_W'(MAX_DIM);

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Register indexes (byte address bit 2)
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [CRD_W-1:0] start_x;
        logic signed [CRD_W-1:0] start_y;
        logic signed [CRD_W-1:0] end_x;
        logic signed [CRD_W-1:0] end_y;
    } cmd_word_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] near_offset;
        logic                near_visible;
        logic [WEIGHT_W-1:0] near_weight;
        logic [OFFSET_W-1:0] far_offset;
        logic                far_visible;
        logic [WEIGHT_W-1:0] far_weight;
        logic                last;
    } pix_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP,
        ST_ORDER,
        ST_DIVIDE,
        ST_LOCATE,
        ST_MULTIPLY,
        ST_SCALE
    } aalr_state_t;

    typedef struct packed {
        logic load_capture;
        logic step_capture;
        logic swap;
        logic order;
        logic div_step;
        logic locate;
        logic multiply;
        logic scale;
    } aalr_cmd_t;

    typedef struct packed {
        logic active;
        logic div_last;
        logic out_free;
    } aalr_status_t;

    function automatic logic signed [CRD_W-1:0] sext_coord(input logic [CRD_W-1:0] v);
        logic signed [CRD_W-1:0] t;
        t = signed'(v << (CRD_W - COORD_BITS));
        return t >>> (CRD_W - COORD_BITS);
    endfunction

endpackage

`default_nettype wire

/* design/aalr_ctrl.sv */
// Sequencer for segment loads and pixel-pair steps.
`timescale 1ns / 1ps
`default_nettype none

module aalr_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    input  wire                  operation,
    input  aalr_pkg::aalr_status_t status,
    output aalr_pkg::aalr_cmd_t  ctrl,
    output logic                 cmd_ready
);
    import aalr_pkg::*;

    aalr_state_t state_reg;
    aalr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        state_next = ST_SWAP;
                    end
                    else if (status.active)
                    begin
                        state_next = ST_LOCATE;
                    end
                end
            end
            ST_SWAP:     state_next = ST_ORDER;
            ST_ORDER:    state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOCATE:   state_next = ST_MULTIPLY;
            ST_MULTIPLY: state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready         = 1'b1;
                ctrl.load_capture = cmd_valid && (operation == OP_LOAD);
                // a step with no live segment is taken and dropped
                ctrl.step_capture = cmd_valid && (operation == OP_STEP) && status.active;
            end
            ST_SWAP:     ctrl.swap     = 1'b1;
            ST_ORDER:    ctrl.order    = 1'b1;
            ST_DIVIDE:   ctrl.div_step = 1'b1;
            ST_LOCATE:   ctrl.locate   = 1'b1;
            ST_MULTIPLY: ctrl.multiply = 1'b1;
            ST_SCALE:    ctrl.scale    = status.out_free;
            default:     ctrl          = '0;
        endcase
    end

endmodule

`default_nettype wire

/* design/aalr_datapath.sv */
// Segment setup, slope divider, step state and pixel address pipeline.
`timescale 1ns / 1ps
`default_nettype none

module aalr_datapath (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  aalr_pkg::aalr_cmd_t                 ctrl,
    output aalr_pkg::aalr_status_t              status,
    input  aalr_pkg::cmd_word_t                 cmd,
    input  wire [aalr_pkg::DIM_W-1:0]           frame_width,
    input  wire [aalr_pkg::DIM_W-1:0]           frame_height,
    output aalr_pkg::pix_word_t                 pix,
    output logic                                pix_valid,
    input  wire                                 pix_ready
);
    import aalr_pkg::*;

    // Raw endpoints and axis-swapped endpoints
    logic signed [CRD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [CRD_W-1:0] a0_reg, b0_reg, a1_reg, b1_reg;

    // Segment state
    logic                      active_reg, active_next;
    logic                      steep_reg;
    logic signed [MAJOR_W-1:0] major_pos_reg, major_end_reg;
    logic signed [PIX_W-1:0]   minor_pos_reg;
    logic                      minor_down_reg;
    logic [WEIGHT_W-1:0]       error_reg, slope_reg;

    // Divider
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [MAJOR_W-1:0]  dvsr_reg;
    logic [WEIGHT_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg;

    // Pixel pipeline
    logic signed [PIX_W-1:0] nx_reg, ny_reg, fx_reg, fy_reg;
    logic [WEIGHT_W-1:0]     nw_reg, fw_reg;
    logic                    last_reg;
    logic                    nvis_reg, fvis_reg;
    logic [ROW_W-1:0]        nrow_reg, ncol_reg, frow_reg, fcol_reg;
    logic [LIN_W-1:0]        nlin_reg, flin_reg;

    pix_word_t pix_reg;
    logic      pix_valid_reg, pix_valid_next;

    // ---------------- setup combinational ----------------
    logic signed [MAJOR_W-1:0] ddx, ddy;
    logic [MAJOR_W-1:0]        adx, ady;
    logic                      steep;

    always_comb
    begin
        ddx   = MAJOR_W'(x1_reg) - MAJOR_W'(x0_reg);
        ddy   = MAJOR_W'(y1_reg) - MAJOR_W'(y0_reg);
        adx   = (ddx < 0) ? MAJOR_W'(-ddx) : MAJOR_W'(ddx);
        ady   = (ddy < 0) ? MAJOR_W'(-ddy) : MAJOR_W'(ddy);
        steep = ady > adx;
    end

    logic                      flip_ends;
    logic signed [CRD_W-1:0]   lo_a, lo_b, hi_a, hi_b;
    logic signed [MAJOR_W-1:0] ddb;
    logic [MAJOR_W-1:0]        seg_dx, seg_dy;

    always_comb
    begin
        flip_ends = a0_reg > a1_reg;
        lo_a      = flip_ends ? a1_reg : a0_reg;
        lo_b      = flip_ends ? b1_reg : b0_reg;
        hi_a      = flip_ends ? a0_reg : a1_reg;
        hi_b      = flip_ends ? b0_reg : b1_reg;
        seg_dx    = MAJOR_W'(MAJOR_W'(hi_a) - MAJOR_W'(lo_a));
        ddb       = MAJOR_W'(hi_b) - MAJOR_W'(lo_b);
        seg_dy    = (ddb < 0) ? MAJOR_W'(-ddb) : MAJOR_W'(ddb);
    end

    // ---------------- restoring divider, one quotient bit a cycle ----------------
    logic             rem_ge;
    logic [REM_W-1:0] rem_sub;

    always_comb
    begin
        rem_ge   = rem_reg >= REM_W'(dvsr_reg);
        rem_sub  = rem_ge ? (rem_reg - REM_W'(dvsr_reg)) : rem_reg;
        rem_next = {rem_sub[REM_W-2:0], 1'b0};
        quo_next = {quo_reg[WEIGHT_W-2:0], rem_ge};
    end

    // ---------------- step combinational ----------------
    logic signed [PIX_W-1:0]   far_minor;
    logic signed [PIX_W-1:0]   major_ext;
    logic                      fin;
    logic [WEIGHT_W-1:0]       err_sum;
    logic                      err_wrap;

    always_comb
    begin
        far_minor = minor_down_reg ? (minor_pos_reg - PIX_W'(1)) : (minor_pos_reg + PIX_W'(1));
        major_ext = PIX_W'(major_pos_reg);
        fin       = major_pos_reg >= major_end_reg;
        err_sum   = error_reg + slope_reg;
        err_wrap  = err_sum >= WEIGHT_ONE;
    end

    // ---------------- locate combinational ----------------
    function automatic logic in_frame(input logic signed [PIX_W-1:0] x,
                                      input logic signed [PIX_W-1:0] y,
                                      input logic [DIM_W-1:0] w,
                                      input logic [DIM_W-1:0] h);
        logic signed [PIX_W-1:0] ws, hs;
        ws = signed'(PIX_W'(w));
        hs = signed'(PIX_W'(h));
        return (x >= 0) && (x < ws) && (y >= 0) && (y < hs);
    endfunction

    function automatic logic [ROW_W-1:0] flip_row(input logic signed [PIX_W-1:0] y,
                                                  input logic [DIM_W-1:0] h);
        logic signed [PIX_W-1:0] r;
        r = signed'(PIX_W'(h)) - PIX_W'(1) - y;
        return r[ROW_W-1:0];
    endfunction

    // ---------------- control registers ----------------
    always_comb
    begin
        active_next = active_reg;
        if (ctrl.load_capture)
        begin
            active_next = 1'b0;
        end
        else if (ctrl.div_step && (cnt_reg == '0))
        begin
            active_next = 1'b1;
        end
        else if (ctrl.step_capture && fin)
        begin
            active_next = 1'b0;
        end

        pix_valid_next = pix_valid_reg;
        if (ctrl.scale)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_ready)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (ctrl.load_capture)
        begin
            x0_reg <= sext_coord(cmd.start_x);
            y0_reg <= sext_coord(cmd.start_y);
            x1_reg <= sext_coord(cmd.end_x);
            y1_reg <= sext_coord(cmd.end_y);
        end

        if (ctrl.swap)
        begin
            steep_reg <= steep;
            a0_reg    <= steep ? y0_reg : x0_reg;
            b0_reg    <= steep ? x0_reg : y0_reg;
            a1_reg    <= steep ? y1_reg : x1_reg;
            b1_reg    <= steep ? x1_reg : y1_reg;
        end

        if (ctrl.order)
        begin
            major_pos_reg  <= MAJOR_W'(lo_a);
            major_end_reg  <= MAJOR_W'(hi_a);
            minor_pos_reg  <= PIX_W'(lo_b);
            minor_down_reg <= !(lo_b < hi_b);
            error_reg      <= '0;
            rem_reg        <= REM_W'(seg_dy);
            dvsr_reg       <= seg_dx;
            quo_reg        <= '0;
            cnt_reg        <= DIV_STEPS;
        end

        if (ctrl.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                // zero-length segment: force a flat slope
                slope_reg <= (dvsr_reg == '0) ? '0 : quo_next;
            end
        end

        if (ctrl.step_capture)
        begin
            nx_reg   <= steep_reg ? minor_pos_reg : major_ext;
            ny_reg   <= steep_reg ? major_ext : minor_pos_reg;
            fx_reg   <= steep_reg ? far_minor : major_ext;
            fy_reg   <= steep_reg ? major_ext : far_minor;
            nw_reg   <= WEIGHT_ONE - error_reg;
            fw_reg   <= error_reg;
            last_reg <= fin;
            if (!fin)
            begin
                major_pos_reg <= major_pos_reg + MAJOR_W'(1);
                if (err_wrap)
                begin
                    error_reg     <= err_sum - WEIGHT_ONE;
                    minor_pos_reg <= far_minor;
                end
                else
                begin
                    error_reg <= err_sum;
                end
            end
        end

        if (ctrl.locate)
        begin
            nvis_reg <= in_frame(nx_reg, ny_reg, frame_width, frame_height);
            fvis_reg <= in_frame(fx_reg, fy_reg, frame_width, frame_height);
            nrow_reg <= flip_row(ny_reg, frame_height);
            frow_reg <= flip_row(fy_reg, frame_height);
            ncol_reg <= nx_reg[ROW_W-1:0];
            fcol_reg <= fx_reg[ROW_W-1:0];
        end

        if (ctrl.multiply)
        begin
            nlin_reg <= (LIN_W'(nrow_reg) * LIN_W'(frame_width)) + LIN_W'(ncol_reg);
            flin_reg <= (LIN_W'(frow_reg) * LIN_W'(frame_width)) + LIN_W'(fcol_reg);
        end

        if (ctrl.scale)
        begin
            pix_reg.near_offset  <= nvis_reg ?
                (OFFSET_W'(nlin_reg) + (OFFSET_W'(nlin_reg) << 1)) : '0;
            pix_reg.near_visible <= nvis_reg;
            pix_reg.near_weight  <= nw_reg;
            pix_reg.far_offset   <= fvis_reg ?
                (OFFSET_W'(flin_reg) + (OFFSET_W'(flin_reg) << 1)) : '0;
            pix_reg.far_visible  <= fvis_reg;
            pix_reg.far_weight   <= fw_reg;
            pix_reg.last         <= last_reg;
        end
    end

    always_comb
    begin
        status.active   = active_reg;
        status.div_last = (cnt_reg == '0);
        status.out_free = !pix_valid_reg || pix_ready;
        pix             = pix_reg;
        pix_valid       = pix_valid_reg;
    end

endmodule

`default_nettype wire

/* design/antialiased_line_rasterizer_unit.sv */
// Step item: the step state is captured, then the LOCATE, MULTIPLY and SCALE states form the result word;
// the next item is taken after SCALE, later while the result register is still held by the consumer.
// Load item: SWAP and ORDER setup states, then the slope divider (one slope bit a cycle).
// One item is in flight at a time; the result register frees the input side once loaded.
// Reset (rst_n low, asynchronous): no segment active, no result pending,
// frame size 640 by 480.
`timescale 1ns / 1ps
`default_nettype none

module antialiased_line_rasterizer_unit (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_ready,
    input  aalr_pkg::cmd_word_t  cmd,
    output logic                 pix_valid,
    input  wire                  pix_ready,
    output aalr_pkg::pix_word_t  pix,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [2:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import aalr_pkg::*;

    logic [DIM_W-1:0] frame_width_reg, frame_width_next;
    logic [DIM_W-1:0] frame_height_reg, frame_height_next;
    logic [DIM_W-1:0] wr_value;
    logic             wr_en;

    aalr_cmd_t    ctrl;
    aalr_status_t status;

    // clamp written size to the largest frame
    always_comb
    begin
        wr_en    = psel && penable && pwrite;
        wr_value = (pwdata[DIM_W-1:0] > DIM_LIMIT) ? DIM_LIMIT : pwdata[DIM_W-1:0];

        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (wr_en)
        begin
            if (paddr[2] == REG_FRAME_WIDTH)
            begin
                frame_width_next = wr_value;
            end
            else
            begin
                frame_height_next = wr_value;
            end
        end

        pready = 1'b1;
        prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(frame_height_reg) : 32'(frame_width_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    aalr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .operation (cmd.operation),
        .status    (status),
        .ctrl      (ctrl),
        .cmd_ready (cmd_ready)
    );

    aalr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cmd          (cmd),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pix          (pix),
        .pix_valid    (pix_valid),
        .pix_ready    (pix_ready)
    );

endmodule

`default_nettype wire
